>>> rtl/wavetable_voice_mixer_macros.svh
// Assertion macros shared by the checker.
`ifndef WAVETABLE_VOICE_MIXER_MACROS_SVH
`define WAVETABLE_VOICE_MIXER_MACROS_SVH

// Check a property outside reset.
`define WVM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wvm check failed");

// Check a property at every edge, reset included.
`define WVM_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("wvm reset check failed");

`endif

>>> rtl/wvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wvm_pkg;

   localparam logic [2:0] OP_MIX    = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_LENGTH = 3'd2;
   localparam logic [2:0] OP_FREQ   = 3'd3;
   localparam logic [2:0] OP_GAINS  = 3'd4;
   localparam logic [2:0] OP_PLAY   = 3'd5;
   localparam logic [2:0] OP_STOP   = 3'd6;
   localparam logic [2:0] OP_REWIND = 3'd7;

   localparam logic [8:0]  UNITY_GAIN = 9'h100;
   localparam logic [19:0] STEP_MAX   = 20'hFFFFF;
   localparam logic [17:0] RATE_RESET = 18'd44100;

   // Decoded command held in the queue between front and back
   typedef struct packed {
      logic [2:0]        opcode;
      logic [2:0]        voice;
      logic              voice_ok;
      logic [11:0]       sample_address;
      logic              addr_ok;
      logic signed [7:0] sample_byte;
      logic [12:0]       length;
      logic [15:0]       frequency;
      logic [8:0]        gain_left;
      logic [8:0]        gain_right;
      logic              loop_mode;
      logic [31:0]       mix_in_left;
      logic [31:0]       mix_in_right;
      logic              frame_last;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/wvm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface wvm_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        opcode;
   logic [2:0]        voice;
   logic [11:0]       sample_address;
   logic signed [7:0] sample_byte;
   logic [12:0]       new_length;
   logic [15:0]       new_frequency;
   logic [8:0]        new_gain_left;
   logic [8:0]        new_gain_right;
   logic              loop_mode;
   logic signed [31:0] mix_in_left;
   logic signed [31:0] mix_in_right;
   logic              frame_last;

   modport source (output valid, opcode, voice, sample_address, sample_byte, new_length,
                   new_frequency, new_gain_left, new_gain_right, loop_mode, mix_in_left,
                   mix_in_right, frame_last, input ready);
   modport sink (input valid, opcode, voice, sample_address, sample_byte, new_length,
                 new_frequency, new_gain_left, new_gain_right, loop_mode, mix_in_left,
                 mix_in_right, frame_last, output ready);
endinterface

interface wvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] mix_out_left;
   logic signed [31:0] mix_out_right;
   logic               out_last;
   logic [7:0]         voices_active;

   modport source (output valid, mix_out_left, mix_out_right, out_last, voices_active,
                   input ready);
   modport sink (input valid, mix_out_left, mix_out_right, out_last, voices_active,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/wvm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/wvm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wvm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [17:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [18:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [17:0] den_ff, den_in;
   logic [18:0] trial;

   // Restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff[17:0], quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> rtl/wvm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wvm_front #(
   parameter int NUM_VOICES = 8,
   parameter int MAX_FRAMES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   wvm_req_if.sink               req,
   output logic                  q_valid,
   output wvm_pkg::cmd_type      q_data,
   input  wire logic             q_pop
);
   import wvm_pkg::*;

   cmd_type    q_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   cmd_type    dec;
   logic       push;

   // Classify and saturate the incoming transaction
   always_comb begin
      dec.opcode         = req.opcode;
      dec.voice          = req.voice;
      dec.voice_ok       = 32'(req.voice) < NUM_VOICES;
      dec.sample_address = req.sample_address;
      dec.addr_ok        = 32'(req.sample_address) < MAX_FRAMES;
      dec.sample_byte    = req.sample_byte;
      if (req.new_length == 13'd0) begin
         dec.length = 13'd1;
      end else if (32'(req.new_length) > MAX_FRAMES) begin
         dec.length = 13'(MAX_FRAMES);
      end else begin
         dec.length = req.new_length;
      end
      dec.frequency  = req.new_frequency;
      dec.gain_left  = (req.new_gain_left > UNITY_GAIN) ? UNITY_GAIN : req.new_gain_left;
      dec.gain_right = (req.new_gain_right > UNITY_GAIN) ? UNITY_GAIN : req.new_gain_right;
      dec.loop_mode    = req.loop_mode;
      dec.mix_in_left  = req.mix_in_left;
      dec.mix_in_right = req.mix_in_right;
      dec.frame_last   = req.frame_last;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (q_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
      if (push) begin
         q_ff[wptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

>>> rtl/wvm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wvm_back #(
   parameter int NUM_VOICES = 8,
   parameter int MAX_FRAMES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [17:0]      csr_write_data,
   input  wire logic             q_valid,
   input  wire wvm_pkg::cmd_type q_data,
   output logic                  q_pop,
   wvm_rsp_if.source             rsp
);
   import wvm_pkg::*;

   localparam int NV = NUM_VOICES;
   localparam int VW = (NV > 1) ? $clog2(NV) : 1;
   localparam int PW = $clog2(MAX_FRAMES);
   localparam int FW = $clog2(MAX_FRAMES + 1);
   localparam int NW = PW + 6;
   localparam int AW = $clog2(NV * MAX_FRAMES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD0  = 3'd1;
   localparam logic [2:0] ST_RD1  = 3'd2;
   localparam logic [2:0] ST_MULA = 3'd3;
   localparam logic [2:0] ST_MULB = 3'd4;
   localparam logic [2:0] ST_WRAP = 3'd5;
   localparam logic [2:0] ST_DIV  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [FW-1:0]  frames_ff [NV];
   logic [PW-1:0]  pos_ff    [NV];
   logic [15:0]    frac_ff   [NV];
   logic [19:0]    step_ff   [NV];
   logic [8:0]     gl_ff     [NV];
   logic [8:0]     gr_ff     [NV];
   logic [NV-1:0]  play_ff, loop_ff;

   logic [2:0]         state_ff;
   logic [VW-1:0]      vcnt_ff;
   logic signed [7:0]  s0_ff;
   logic               s1zero_ff;
   logic signed [17:0] value_ff;
   logic [31:0]        accl_ff, accr_ff;
   logic               last_ff;
   logic [NW-1:0]      posw_ff;
   logic [17:0]        rate_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_left_ff, rsp_right_ff;
   logic               rsp_last_ff;
   logic [7:0]         rsp_active_ff;

   logic [VW-1:0]      cv;
   logic [AW-1:0]      base, rd_addr, wr_addr;
   logic               ram_we;
   logic [7:0]         ram_rd;
   logic [NW-1:0]      nxt1, frames_n, npos;
   logic [PW-1:0]      s1_idx;
   logic               s1_in;
   logic signed [7:0]  s1;
   logic signed [17:0] a0, w0, a1, w1;
   logic [8:0]         sub;
   logic signed [27:0] vx, glx, grx, plx, prx;
   logic [20:0]        fsum;
   logic               last_voice;
   logic               div_start, div_done;
   logic [31:0]        div_q;
   logic [19:0]        step_sat;
   logic [7:0]         active;
   logic               out_free;

   assign cv       = vcnt_ff;
   assign base     = AW'(cv) * AW'(MAX_FRAMES);
   assign nxt1     = NW'(pos_ff[cv]) + NW'(1);
   assign frames_n = NW'(frames_ff[cv]);
   assign s1_in    = nxt1 < frames_n;
   assign s1_idx   = s1_in ? PW'(nxt1) : '0;
   assign wr_addr  = AW'(VW'(q_data.voice)) * AW'(MAX_FRAMES) + AW'(q_data.sample_address);
   assign ram_we   = (state_ff == ST_IDLE) && q_valid && q_data.voice_ok &&
                     (q_data.opcode == OP_WRITE) && q_data.addr_ok;
   assign rd_addr  = (state_ff == ST_RD1) ? base + AW'(s1_idx) : base + AW'(pos_ff[cv]);

   // Interpolation weights
   assign sub = {1'b0, frac_ff[cv][15:8]};
   assign s1  = (state_ff == ST_MULA && !s1zero_ff) ? $signed(ram_rd) : 8'sd0;
   assign a0  = 18'(s0_ff);
   assign w0  = $signed(18'(UNITY_GAIN - sub));
   assign a1  = 18'(s1);
   assign w1  = $signed(18'(sub));

   // Gain scaling and position advance
   assign vx   = 28'(value_ff);
   assign glx  = $signed(28'(gl_ff[cv]));
   assign grx  = $signed(28'(gr_ff[cv]));
   assign plx  = vx * glx;
   assign prx  = vx * grx;
   assign fsum = 21'(frac_ff[cv]) + 21'(step_ff[cv]);
   assign npos = NW'(pos_ff[cv]) + NW'(fsum[20:16]);

   assign last_voice = (32'(vcnt_ff) == NV - 1);
   assign step_sat   = (div_q > 32'(STEP_MAX)) ? STEP_MAX : div_q[19:0];
   assign div_start  = (state_ff == ST_IDLE) && q_valid && q_data.voice_ok &&
                       (q_data.opcode == OP_FREQ) && (q_data.frequency != 16'd0);
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      active = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < NV) begin
            active[i] = play_ff[i];
         end
      end
   end

   wvm_ram #(.WIDTH(8), .DEPTH(NV * MAX_FRAMES)) u_samples (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (q_data.sample_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   wvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({q_data.frequency, 16'd0}),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
         play_ff      <= '0;
         loop_ff      <= '0;
         for (int i = 0; i < NV; i++) begin
            frames_ff[i] <= FW'(1);
            pos_ff[i]    <= '0;
            frac_ff[i]   <= '0;
            step_ff[i]   <= '0;
            gl_ff[i]     <= UNITY_GAIN;
            gr_ff[i]     <= UNITY_GAIN;
         end
      end else begin
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  accl_ff <= '0;
                  accr_ff <= '0;
                  last_ff <= 1'b0;
                  state_ff <= ST_DONE;
                  if (q_data.opcode == OP_MIX) begin
                     accl_ff  <= q_data.mix_in_left;
                     accr_ff  <= q_data.mix_in_right;
                     last_ff  <= q_data.frame_last;
                     vcnt_ff  <= '0;
                     state_ff <= ST_RD0;
                  end else if (q_data.voice_ok) begin
                     vcnt_ff <= VW'(q_data.voice);
                     case (q_data.opcode)
                        OP_LENGTH: begin
                           frames_ff[VW'(q_data.voice)] <= FW'(q_data.length);
                           play_ff[VW'(q_data.voice)]   <= 1'b0;
                           pos_ff[VW'(q_data.voice)]    <= '0;
                           frac_ff[VW'(q_data.voice)]   <= '0;
                           gl_ff[VW'(q_data.voice)]     <= UNITY_GAIN;
                           gr_ff[VW'(q_data.voice)]     <= UNITY_GAIN;
                        end
                        OP_FREQ: begin
                           if (q_data.frequency == 16'd0) begin
                              step_ff[VW'(q_data.voice)] <= '0;
                           end else begin
                              state_ff <= ST_DIV;
                           end
                        end
                        OP_GAINS: begin
                           gl_ff[VW'(q_data.voice)] <= q_data.gain_left;
                           gr_ff[VW'(q_data.voice)] <= q_data.gain_right;
                        end
                        OP_PLAY: begin
                           play_ff[VW'(q_data.voice)] <= 1'b1;
                           loop_ff[VW'(q_data.voice)] <= q_data.loop_mode;
                        end
                        OP_STOP: begin
                           play_ff[VW'(q_data.voice)] <= 1'b0;
                        end
                        OP_REWIND: begin
                           pos_ff[VW'(q_data.voice)]  <= '0;
                           frac_ff[VW'(q_data.voice)] <= '0;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            ST_RD0: begin
               if (play_ff[cv]) begin
                  state_ff <= ST_RD1;
               end else if (last_voice) begin
                  state_ff <= ST_DONE;
               end else begin
                  vcnt_ff <= vcnt_ff + VW'(1);
               end
            end
            ST_RD1: begin
               s0_ff     <= $signed(ram_rd);
               s1zero_ff <= !s1_in && !loop_ff[cv];
               state_ff  <= ST_MULA;
            end
            ST_MULA: begin
               value_ff <= a0 * w0 + a1 * w1;
               state_ff <= ST_MULB;
            end
            ST_MULB: begin
               accl_ff <= accl_ff + 32'($signed(plx[27:8]));
               accr_ff <= accr_ff + 32'($signed(prx[27:8]));
               frac_ff[cv] <= fsum[15:0];
               if (npos >= frames_n && loop_ff[cv]) begin
                  posw_ff  <= npos;
                  state_ff <= ST_WRAP;
               end else begin
                  if (npos >= frames_n) begin
                     play_ff[cv] <= 1'b0;
                     pos_ff[cv]  <= '0;
                     frac_ff[cv] <= '0;
                  end else begin
                     pos_ff[cv] <= PW'(npos);
                  end
                  if (last_voice) begin
                     state_ff <= ST_DONE;
                  end else begin
                     vcnt_ff  <= vcnt_ff + VW'(1);
                     state_ff <= ST_RD0;
                  end
               end
            end
            ST_WRAP: begin
               if (posw_ff >= frames_n) begin
                  posw_ff <= posw_ff - frames_n;
               end else begin
                  pos_ff[cv] <= PW'(posw_ff);
                  if (last_voice) begin
                     state_ff <= ST_DONE;
                  end else begin
                     vcnt_ff  <= vcnt_ff + VW'(1);
                     state_ff <= ST_RD0;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  step_ff[cv] <= step_sat;
                  state_ff    <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_left_ff   <= accl_ff;
                  rsp_right_ff  <= accr_ff;
                  rsp_last_ff   <= last_ff;
                  rsp_active_ff <= active;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.mix_out_left  = rsp_left_ff;
   assign rsp.mix_out_right = rsp_right_ff;
   assign rsp.out_last      = rsp_last_ff;
   assign rsp.voices_active = rsp_active_ff;
endmodule
`default_nettype wire

>>> rtl/wavetable_voice_mixer.sv
// Flow: a non-mix command passes the queue, ST_DONE and the result register; set frequency
// also waits in ST_DIV for the bit-serial step divider.
// Mix frame: ST_RD0, ST_RD1, ST_MULA and ST_MULB per playing voice, ST_RD0 per idle voice,
// plus, for a looping voice that wraps, ST_WRAP for each wrap subtraction and to store the
// wrapped position; the single sample RAM read port sets the voice cost.
// Reset: synchronous, clears the command queue, voice state and output_rate (44100);
// sample memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module wavetable_voice_mixer #(
   parameter int NUM_VOICES = 8,
   parameter int MAX_FRAMES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [17:0] csr_write_data,
   wvm_req_if.sink          req,
   wvm_rsp_if.source        rsp
);
   import wvm_pkg::*;

   // Decoded command queue between front and back
   logic    q_valid;
   logic    q_pop;
   cmd_type q_data;

   // Front: accept each transaction, classify it, saturate its fields, queue it
   wvm_front #(.NUM_VOICES(NUM_VOICES), .MAX_FRAMES(MAX_FRAMES)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   // Back: execute commands, walk the voices on a mix, hold the result register
   wvm_back #(.NUM_VOICES(NUM_VOICES), .MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp              (rsp)
   );
endmodule
`default_nettype wire

>>> rtl/wvm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wavetable_voice_mixer_macros.svh"
module wvm_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_mix_out_left,
   input wire logic [31:0] rsp_mix_out_right,
   input wire logic        rsp_out_last,
   input wire logic [7:0]  rsp_voices_active
);
   logic [72:0] rsp_payload;

   assign rsp_payload = {rsp_mix_out_left, rsp_mix_out_right, rsp_out_last, rsp_voices_active};

   // Reset empties the result register and the queue
   `WVM_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid)
   `WVM_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_ready)
   // Hold a stalled result
   `WVM_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid)
   `WVM_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload))
endmodule

bind wavetable_voice_mixer wvm_props u_wvm_props (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_mix_out_left  (rsp.mix_out_left),
   .rsp_mix_out_right (rsp.mix_out_right),
   .rsp_out_last      (rsp.out_last),
   .rsp_voices_active (rsp.voices_active)
);
`default_nettype wire
